@@ rtl/rgb_hsi_color_mask_macros.svh @@
// assertion macros for the rgb_hsi_color_mask checker
// expects clk and rst in the scope where a macro is used
`ifndef RGB_HSI_COLOR_MASK_MACROS_SVH
`define RGB_HSI_COLOR_MASK_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RHCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rgb_hsi_color_mask check failed");

// condition that must never be seen outside reset
`define RHCM_NEVER(lbl, cond) \
  `RHCM_ASSERT(lbl, !(cond))

`endif

@@ rtl/rhcm_pkg.sv @@
// shared types, constants and angle tables for rgb_hsi_color_mask
// no dependencies
package rhcm_pkg;

  localparam int unsigned HueW = 9;
  localparam int unsigned PctW = 7;
  localparam int unsigned ChW  = 8;
  localparam int unsigned AddrW = 5;

  localparam logic [HueW-1:0] HueMinRst   = 9'd312;
  localparam logic [HueW-1:0] HueMaxRst   = 9'd360;
  localparam logic [PctW-1:0] SatMinRst   = 7'd17;
  localparam logic [PctW-1:0] SatMaxRst   = 7'd100;
  localparam logic [PctW-1:0] IntFloorRst = 7'd18;
  localparam logic [PctW-1:0] IntCeilRst  = 7'd100;

  // search steps of the hue binary search (one per degree bit)
  localparam int unsigned SearchSteps = 8;

  // register index on the configuration port
  typedef enum logic [2:0] {
    REG_HUE_MIN  = 3'd0,
    REG_HUE_MAX  = 3'd1,
    REG_SAT_MIN  = 3'd2,
    REG_SAT_MAX  = 3'd3,
    REG_INT_FLR  = 3'd4,
    REG_INT_CEIL = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [ChW-1:0] pix_red;
    logic [ChW-1:0] pix_green;
    logic [ChW-1:0] pix_blue;
  } pixel_t;

  typedef struct packed {
    logic            matched;
    logic [HueW-1:0] hue_deg;
    logic [PctW-1:0] sat_pct;
    logic [PctW-1:0] int_pct;
    logic [ChW-1:0]  kept_red;
    logic [ChW-1:0]  kept_green;
    logic [ChW-1:0]  kept_blue;
  } result_t;

  // item state carried down the search pipeline
  typedef struct packed {
    logic               valid;
    pixel_t             pix;
    logic signed [10:0] x;
    logic [7:0]         y;
    logic [9:0]         sum;
    logic [16:0]        rem;
    logic [7:0]         quo;
    logic [7:0]         deg;
    logic [PctW-1:0]    inten;
    logic               gray;
    logic               lowsat;
  } step_t;

  typedef logic signed [63:0] coef_tab_t [256];

  // sin(d) in Q52
  function automatic coef_tab_t make_sin();
    coef_tab_t tab;
    real rad;
    for (int d = 0; d < 256; d++) begin
      rad = d * 3.14159265358979323846 / 180.0;
      tab[d] = longint'($sin(rad) * 4503599627370496.0);
    end
    return tab;
  endfunction

  // sqrt3*cos(d) in Q52
  function automatic coef_tab_t make_kcos();
    coef_tab_t tab;
    real rad;
    for (int d = 0; d < 256; d++) begin
      rad = d * 3.14159265358979323846 / 180.0;
      tab[d] = longint'($sqrt(3.0) * $cos(rad) * 4503599627370496.0);
    end
    return tab;
  endfunction

  localparam coef_tab_t SinTab  = make_sin();
  localparam coef_tab_t KcosTab = make_kcos();

  // angle of (x, sqrt3*y) is at least d degrees; multiples of 30 are exact
  function automatic logic angle_ok(logic [7:0] d, logic signed [10:0] x,
                                    logic [7:0] y);
    logic signed [11:0] xs;
    logic signed [11:0] ys;
    logic signed [11:0] y3;
    logic signed [65:0] lhs;
    logic signed [65:0] rhs;
    logic ok;
    xs  = 12'(x);
    ys  = $signed({4'b0, y});
    y3  = 12'(ys * 12'sd3);
    lhs = 66'(KcosTab[d]) * 66'(ys);
    rhs = 66'(SinTab[d]) * 66'(x);
    case (d)
      8'd30:   ok = (xs <= y3);
      8'd60:   ok = (xs <= ys);
      8'd90:   ok = (xs <= 12'sd0);
      8'd120:  ok = (xs <= -ys);
      8'd150:  ok = (xs <= -y3);
      8'd180:  ok = (y == 8'd0) && (xs < 12'sd0);
      default: ok = (lhs >= rhs);
    endcase
    return ok;
  endfunction

endpackage

@@ rtl/rhcm_step.sv @@
// one register stage of the hue search and saturation divider
// depends on rhcm_pkg
module rhcm_step #(
  parameter int unsigned BIT = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  rhcm_pkg::step_t din,
  output rhcm_pkg::step_t dout
);
  import rhcm_pkg::*;

  logic [7:0]  cand;
  logic        take;
  logic [17:0] dsh;
  logic        sub;
  step_t       nxt;

  // try the next degree bit, and one quotient bit of 300*min/sum
  always_comb begin
    cand = din.deg | 8'(1 << BIT);
    take = (cand <= 8'd180) && angle_ok(cand, din.x, din.y);
    dsh  = 18'(din.sum) << BIT;
    sub  = ({1'b0, din.rem} >= dsh);
    nxt  = din;
    if (take) begin
      nxt.deg = cand;
    end
    if (sub) begin
      nxt.rem = 17'({1'b0, din.rem} - dsh);
      nxt.quo = din.quo | 8'(1 << BIT);
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

@@ rtl/rgb_hsi_color_mask.sv @@
// top level: RGB to HSI conversion with window match and pixel masking
// depends on rhcm_pkg and rhcm_step
//
// One pixel is taken in every clock cycle (busy stays low). Its result is on
// result with done high once it has passed the registers of the pipeline:
// one input stage, eight search stages that each settle one bit of the hue
// degree and one bit of the saturation quotient, and one output stage.
// Results cannot be held off. Window registers should only be written while
// no pixel is in flight.
module rgb_hsi_color_mask (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rhcm_pkg::pixel_t              pixel,
  output logic                          done,
  output rhcm_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rhcm_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rhcm_pkg::*;

  logic [HueW-1:0] hue_min, hue_max;
  logic [PctW-1:0] sat_min, sat_max, int_floor, int_ceiling;
  logic            wr_en;
  reg_idx_t        widx;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_min     <= HueMinRst;
      hue_max     <= HueMaxRst;
      sat_min     <= SatMinRst;
      sat_max     <= SatMaxRst;
      int_floor   <= IntFloorRst;
      int_ceiling <= IntCeilRst;
    end else if (wr_en) begin
      case (widx)
        REG_HUE_MIN:  hue_min     <= pwdata[HueW-1:0];
        REG_HUE_MAX:  hue_max     <= pwdata[HueW-1:0];
        REG_SAT_MIN:  sat_min     <= pwdata[PctW-1:0];
        REG_SAT_MAX:  sat_max     <= pwdata[PctW-1:0];
        REG_INT_FLR:  int_floor   <= pwdata[PctW-1:0];
        REG_INT_CEIL: int_ceiling <= pwdata[PctW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (widx)
      REG_HUE_MIN:  prdata = 32'(hue_min);
      REG_HUE_MAX:  prdata = 32'(hue_max);
      REG_SAT_MIN:  prdata = 32'(sat_min);
      REG_SAT_MAX:  prdata = 32'(sat_max);
      REG_INT_FLR:  prdata = 32'(int_floor);
      REG_INT_CEIL: prdata = 32'(int_ceiling);
      default:      prdata = 32'd0;
    endcase
  end

  // input stage: sums, min, hue coordinates, intensity
  logic [7:0]         r, g, b, mn;
  logic signed [11:0] xw;
  logic [37:0]        iprod;
  step_t              prep_next;
  step_t              pipe [SearchSteps+1];

  always_comb begin
    r  = pixel.pix_red;
    g  = pixel.pix_green;
    b  = pixel.pix_blue;
    mn = (g < r) ? g : r;
    mn = (b < mn) ? b : mn;
    xw = $signed({3'b0, r, 1'b0}) - $signed({4'b0, g}) - $signed({4'b0, b});
    prep_next.valid = start & ~busy;
    prep_next.pix   = pixel;
    prep_next.x     = xw[10:0];
    prep_next.y     = (g >= b) ? 8'(g - b) : 8'(b - g);
    prep_next.sum   = 10'(r) + 10'(g) + 10'(b);
    prep_next.rem   = 17'({9'b0, mn} * 17'd300);
    prep_next.quo   = 8'd0;
    prep_next.deg   = 8'd0;
    // sum*100/765 via a reciprocal multiply, exact over the whole range
    iprod           = 38'(prep_next.sum) * 38'd140358420;
    prep_next.inten = iprod[36:30];
    prep_next.gray  = (r == g) && (g == b);
    prep_next.lowsat = (17'({7'b0, prep_next.sum} * 17'd99) <= prep_next.rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0] <= '0;
    end else begin
      pipe[0] <= prep_next;
    end
  end

  // search stages, most significant degree bit first
  for (genvar i = 0; i < SearchSteps; i++) begin : g_step
    rhcm_step #(.BIT(SearchSteps - 1 - i)) u_step (
      .clk  (clk),
      .rst  (rst),
      .din  (pipe[i]),
      .dout (pipe[i+1])
    );
  end

  // output stage: mirror, special cases, window match
  step_t           fin;
  logic            whole;
  logic [HueW-1:0] hue;
  logic [PctW-1:0] sat;
  logic            hit;
  logic signed [11:0] fx, fy, fy3;
  result_t         res_next;

  always_comb begin
    fin   = pipe[SearchSteps];
    fx    = 12'(fin.x);
    fy    = $signed({4'b0, fin.y});
    fy3   = 12'(fy * 12'sd3);
    whole = (fx == fy3) || (fx == fy) || (fx == 12'sd0) || (fx == -fy) ||
            (fx == -fy3);
    if (fin.pix.pix_blue <= fin.pix.pix_green) begin
      hue = 9'(fin.deg);
    end else begin
      hue = 9'd360 - 9'(fin.deg) - (whole ? 9'd0 : 9'd1);
    end
    sat = 7'(8'd100 - fin.quo - ((fin.rem != 17'd0) ? 8'd1 : 8'd0));
    if (fin.gray) begin
      hue = '0;
      sat = '0;
    end else if (fin.lowsat) begin
      hue = '0;
    end
    hit = (hue >= hue_min) && (hue <= hue_max) && (sat >= sat_min) &&
          (sat <= sat_max) && (fin.inten > int_floor) &&
          (fin.inten < int_ceiling);
    res_next.matched    = hit;
    res_next.hue_deg    = hue;
    res_next.sat_pct    = sat;
    res_next.int_pct    = fin.inten;
    res_next.kept_red   = hit ? fin.pix.pix_red : 8'd0;
    res_next.kept_green = hit ? fin.pix.pix_green : 8'd0;
    res_next.kept_blue  = hit ? fin.pix.pix_blue : 8'd0;
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

endmodule

@@ rtl/rhcm_checker.sv @@
// port-level checks for rgb_hsi_color_mask, bound to the top level
// depends on rhcm_pkg and rgb_hsi_color_mask_macros.svh
`include "rgb_hsi_color_mask_macros.svh"

module rhcm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input rhcm_pkg::result_t          result
);
  import rhcm_pkg::*;

  // every accepted item yields a result with done high
  `RHCM_ASSERT(a_lat, (start && !busy) |-> ##10 done)
  // no result without an accepted item ahead of it in the pipeline
  `RHCM_ASSERT(a_noghost, (!(start && !busy)) |-> ##10 !done)
  // an unmatched item shows black
  `RHCM_NEVER(a_black, done && !result.matched &&
    (result.kept_red != 8'd0 || result.kept_green != 8'd0 ||
     result.kept_blue != 8'd0))
  // hue and saturation stay in range
  `RHCM_NEVER(a_range, done && (result.hue_deg > 9'd359 || result.sat_pct > 7'd100))

endmodule

bind rgb_hsi_color_mask rhcm_checker u_rhcm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
